// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define CDAD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdad assertion failed");

// Next-cycle implication, reset-qualified.
`define CDAD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdad assertion failed");

`endif

// ----- design/cdad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cdad_pkg;

	localparam int DAYS_WIDTH = 12;
	localparam int DAY_W      = DAYS_WIDTH + 1;
	localparam int YEAR_W     = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = YEAR_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 2'd1;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1950;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2020;

	// year / 100 == (year * RECIP_100) >> RECIP_SHIFT for every 14-bit year
	localparam int RECIP_W     = 13;
	localparam int PROD_W      = YEAR_W + RECIP_W;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int CENT_W      = PROD_W - RECIP_SHIFT;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;
	localparam logic [3:0] MON_DEC = 4'd12;

	localparam logic [4:0] LEN_SHORT = 5'd30;
	localparam logic [4:0] LEN_LONG  = 5'd31;
	localparam logic [4:0] LEN_FEB   = 5'd28;

	localparam logic [6:0] LAST_YY = 7'd99;

	typedef struct packed {
		logic [4:0]            start_day;
		logic [3:0]            start_month;
		logic [YEAR_W-1:0]     start_year;
		logic [DAYS_WIDTH-1:0] days_to_add;
	} cdad_in_t;

	typedef struct packed {
		logic [4:0]        end_day;
		logic [3:0]        end_month;
		logic [YEAR_W-1:0] end_year;
		logic              start_valid;
	} cdad_out_t;

	typedef struct packed {
		logic load;
		logic split;
		logic check;
		logic step;
		logic finish;
	} cdad_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_CHECK,
		ST_STEP
	} cdad_state_t;

	// yy = year mod 100, cc = (year / 100) mod 4
	function automatic logic is_leap(input logic [6:0] yy, input logic [1:0] cc,
			input logic [1:0] y_lo);
		return (yy != 7'd0) ? (y_lo == 2'd0) : (cc == 2'd0);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
			MON_FEB: len = LEN_FEB + {4'd0, leap};
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ----- design/cdad_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cdad_fsm (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 more,
	output cdad_pkg::cdad_ctrl_t ctrl,
	output logic                busy,
	output logic                done
);
	import cdad_pkg::*;

	cdad_state_t state_q, state_d;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.finish;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				ctrl.split = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				ctrl.check = 1'b1;
				state_d    = ST_STEP;
			end
			ST_STEP: begin
				if (more) begin
					ctrl.step = 1'b1;
				end else begin
					ctrl.finish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

// ----- design/cdad_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cdad_datapath (
	input  wire                          clk,
	input  cdad_pkg::cdad_ctrl_t         ctrl,
	input  cdad_pkg::cdad_in_t           in_item,
	input  wire [cdad_pkg::YEAR_W-1:0]   min_year,
	input  wire [cdad_pkg::YEAR_W-1:0]   max_year,
	output logic                         more,
	output cdad_pkg::cdad_out_t          result
);
	import cdad_pkg::*;

	logic [DAY_W-1:0]  day_q;
	logic [3:0]        mon_q;
	logic [YEAR_W-1:0] yr_q;
	logic [4:0]        sd_q;
	logic [PROD_W-1:0] prod_q;
	logic [6:0]        yy_q;
	logic [1:0]        cc_q;
	logic              valid_q;
	cdad_out_t         result_q;

	logic [CENT_W-1:0] cent;
	logic [YEAR_W-1:0] cent_x100;
	logic [YEAR_W-1:0] yy_full;
	logic              leap;
	logic [4:0]        len;
	logic              wrap;
	logic              yr_top;

	assign cent      = prod_q[PROD_W-1:RECIP_SHIFT];
	assign cent_x100 = YEAR_W'({6'd0, cent} * 14'd100);
	assign yy_full   = yr_q - cent_x100;

	assign leap   = is_leap(yy_q, cc_q, yr_q[1:0]);
	assign len    = month_len(mon_q, leap);
	assign more   = day_q > DAY_W'(len);
	assign wrap   = mon_q >= MON_DEC;
	assign yr_top = &yr_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			day_q  <= DAY_W'(in_item.start_day) + DAY_W'(in_item.days_to_add);
			mon_q  <= in_item.start_month;
			yr_q   <= in_item.start_year;
			sd_q   <= in_item.start_day;
			prod_q <= PROD_W'(in_item.start_year) * PROD_W'(RECIP_100);
		end
		if (ctrl.split) begin
			yy_q <= yy_full[6:0];
			cc_q <= cent[1:0];
		end
		if (ctrl.check) begin
			valid_q <= (yr_q >= min_year) && (yr_q <= max_year) &&
				(mon_q >= MON_JAN) && (mon_q <= MON_DEC) &&
				(sd_q != 5'd0) && (sd_q <= len);
		end
		if (ctrl.step) begin
			day_q <= day_q - DAY_W'(len);
			if (wrap) begin
				mon_q <= MON_JAN;
				yr_q  <= yr_q + 1'b1;
				if (yr_top) begin
					yy_q <= 7'd0;
					cc_q <= 2'd0;
				end else if (yy_q == LAST_YY) begin
					yy_q <= 7'd0;
					cc_q <= cc_q + 1'b1;
				end else begin
					yy_q <= yy_q + 1'b1;
				end
			end else begin
				mon_q <= mon_q + 1'b1;
			end
		end
		if (ctrl.finish) begin
			result_q.end_day     <= day_q[4:0];
			result_q.end_month   <= mon_q;
			result_q.end_year    <= yr_q;
			result_q.start_valid <= valid_q;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

// ----- design/calendar_date_add_days_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Gregorian date adder: start date plus a day count, with a start-date check.
// Input: an item is taken at a clock edge with start high and busy low.
//   busy stays high until the result is out; no new item is taken meanwhile.
// Output: done is high for one cycle with the result on result; the
//   receiver cannot stall, so the result must be captured in that cycle.
//   result holds its value until the next item finishes.
// Sequence: the accepting edge loads the item, then the split state splits
//   the year into mod-100 and century-mod-4 counters, the check state forms
//   start_valid, and the step state steps over N months (one month per cycle
//   through a subtract/compare unit) and then registers the result. With
//   12-bit day counts N is at most about 136, and the next item can be
//   accepted in the cycle done is high.
// Config: cfg_we writes cfg_data to register cfg_idx (0 min_year,
//   1 max_year); other indexes are ignored. Write only while idle.
// Reset: arst_n clears control, returns to idle and reloads the year window
//   to 1950..2020.
module calendar_date_add_days_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  cdad_pkg::cdad_in_t             in_item,
	output logic                           busy,
	output logic                           done,
	output cdad_pkg::cdad_out_t            result,
	input  wire                            cfg_we,
	input  wire [cdad_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire [cdad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cdad_pkg::*;

`include "assert_macros.svh"

	logic [YEAR_W-1:0] min_year_q;
	logic [YEAR_W-1:0] max_year_q;
	cdad_ctrl_t        ctrl;
	logic              more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MIN_YEAR: min_year_q <= cfg_data;
				CFG_MAX_YEAR: max_year_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cdad_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.more   (more),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	cdad_datapath u_dp (
		.clk      (clk),
		.ctrl     (ctrl),
		.in_item  (in_item),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.more     (more),
		.result   (result)
	);

	`CDAD_ASSERT_IMP(a_done_not_busy, done, !busy)
	`CDAD_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done)
	`CDAD_ASSERT_NXT(a_finish_done, ctrl.finish, done)
	`CDAD_ASSERT_IMP(a_one_ctrl, busy || done || !busy, $onehot0(ctrl))

endmodule
`default_nettype wire

// ----- tb/calendar_date_add_days_unit_test.sv -----
`timescale 1ns / 1ps
module calendar_date_add_days_unit_test;
	import cdad_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int YEAR_MASK = 16'h3FFF;
	localparam int DAYS_MAX = (1 << DAYS_WIDTH) - 1;
	localparam int PRINT_CAP = 100;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cdad_in_t in_item = '0;
	logic busy;
	logic done;
	cdad_out_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int win_lo;
	int win_hi;
	cdad_out_t pending_dates[$];
	cdad_out_t want;
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;

	calendar_date_add_days_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_item(in_item),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic bit leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int days_in_month(input int m, input int y);
		if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
			return LEN_SHORT;
		if (m == MON_FEB)
			return LEN_FEB + leap_year(y);
		return LEN_LONG;
	endfunction

	function automatic cdad_out_t predict_date(input cdad_in_t it);
		cdad_out_t r;
		int d, m, y, len;
		d = int'(it.start_day) + int'(it.days_to_add);
		m = it.start_month;
		y = it.start_year;
		r.start_valid = (y >= win_lo) && (y <= win_hi) && (m >= MON_JAN) && (m <= MON_DEC)
			&& (it.start_day >= 1) && (it.start_day <= days_in_month(m, y));
		len = days_in_month(m, y);
		while (d > len) begin
			d -= len;
			m++;
			if (m > MON_DEC) begin
				m = MON_JAN;
				y = (y + 1) & YEAR_MASK;
			end
			len = days_in_month(m, y);
		end
		r.end_day = 5'(d);
		r.end_month = 4'(m);
		r.end_year = YEAR_W'(y);
		return r;
	endfunction

	function automatic cdad_in_t make_date(input int d, input int m, input int y, input int n);
		cdad_in_t it;
		it.start_day = 5'(d);
		it.start_month = 4'(m);
		it.start_year = YEAR_W'(y);
		it.days_to_add = DAYS_WIDTH'(n);
		return it;
	endfunction

	// mostly well-formed dates around the year window, some raw field noise
	function automatic cdad_in_t rand_date();
		cdad_in_t it;
		int kind, y, m, len;
		kind = $urandom_range(0, 9);
		if (kind < 8) begin
			case (kind)
				6: y = (win_lo - 1) & YEAR_MASK;
				7: y = (win_hi + $urandom_range(0, 1)) & YEAR_MASK;
				default: y = $urandom_range(win_lo, win_hi);
			endcase
			m = $urandom_range(MON_JAN, MON_DEC);
			len = days_in_month(m, y);
			it.start_year = YEAR_W'(y);
			it.start_month = 4'(m);
			it.start_day = 5'((kind == 5) ? len + 1 : $urandom_range(1, len));
		end else begin
			it.start_day = 5'($urandom_range(0, 31));
			it.start_month = 4'($urandom_range(0, 15));
			it.start_year = YEAR_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, YEAR_MASK)
				: $urandom_range(0, 9999));
		end
		it.days_to_add = DAYS_WIDTH'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 62)
			: $urandom_range(0, DAYS_MAX));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_v);
		if (mismatches < PRINT_CAP)
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp_v, $time);
		mismatches++;
	endtask

	task automatic send_date(input cdad_in_t it);
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		pending_dates.push_back(predict_date(it));
	endtask

	// bursts of items with random gaps; some bursts run without a gap
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_dates();
		start <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_YEAR)
			win_lo = val & YEAR_MASK;
		else if (idx == CFG_MAX_YEAR)
			win_hi = val & YEAR_MASK;
		@(posedge clk);
	endtask

	task automatic send_paced(input cdad_in_t it);
		send_date(it);
		pace_sender();
	endtask

	task automatic test_default_window();
		send_paced(make_date(0, 0, 0, 0));
		send_paced(make_date(31, 15, YEAR_MASK, DAYS_MAX));
		send_paced(make_date(31, 12, 2019, 1));
		send_paced(make_date(28, 2, 2000, 1));
		send_paced(make_date(28, 2, 1900, 1));
		send_paced(make_date(29, 2, 2020, 0));
		send_paced(make_date(29, 2, 2019, 0));
		send_paced(make_date(30, 4, 2000, 1));
		send_paced(make_date(31, 4, 2000, 0));
		send_paced(make_date(15, 0, 2000, 20));
		send_paced(make_date(31, 13, 2000, 1));
		send_paced(make_date(1, 15, 2005, 40));
		send_paced(make_date(1, 1, 1950, 0));
		send_paced(make_date(31, 12, 1949, 0));
		send_paced(make_date(31, 12, 2020, 0));
		send_paced(make_date(1, 1, 2021, 0));
		send_paced(make_date(1, 1, 2000, DAYS_MAX));
		send_paced(make_date(0, 5, 2000, 0));
		send_paced(make_date(31, 12, YEAR_MASK, 1));
		send_paced(make_date(1, 1, 0, 366));
		send_paced(make_date(1, 3, 2100, 365));
		send_paced(make_date(1, 3, 2400, 366));
		drain_dates();
	endtask

	task automatic test_year_window();
		int lows[5] = '{0, 9999, 0, 2000, YEAR_MASK};
		int highs[5] = '{9999, 0, 0, 2000, YEAR_MASK};
		for (int i = 0; i < 5; i++) begin
			write_window_reg(CFG_MIN_YEAR, lows[i]);
			write_window_reg(CFG_MAX_YEAR, highs[i]);
			if (i == 0) begin
				// spare indexes must leave the window alone
				write_window_reg(CFG_SPARE_LO, $urandom_range(0, YEAR_MASK));
				write_window_reg(CFG_SPARE_HI, $urandom_range(0, YEAR_MASK));
			end
			send_paced(make_date(15, 6, (lows[i] - 1) & YEAR_MASK, $urandom_range(0, 400)));
			send_paced(make_date(15, 6, lows[i], $urandom_range(0, 400)));
			send_paced(make_date(15, 6, highs[i], $urandom_range(0, 400)));
			send_paced(make_date(15, 6, (highs[i] + 1) & YEAR_MASK, $urandom_range(0, 400)));
			drain_dates();
		end
	endtask

	task automatic test_random_dates();
		int lows[4] = '{1900, 2020, 0, 1582};
		int highs[4] = '{2100, 1950, YEAR_MASK, 9999};
		for (int p = 0; p < 4; p++) begin
			write_window_reg(CFG_MIN_YEAR, lows[p]);
			write_window_reg(CFG_MAX_YEAR, highs[p]);
			for (int i = 0; i < 250; i++) begin
				send_paced(rand_date());
				if (p == 1 && i == 125)
					drain_dates();
			end
			drain_dates();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("result with no item pending", int'(result), 0);
			end else begin
				want = pending_dates.pop_front();
				if (result.end_day !== want.end_day)
					report_mismatch("end_day", result.end_day, want.end_day);
				if (result.end_month !== want.end_month)
					report_mismatch("end_month", result.end_month, want.end_month);
				if (result.end_year !== want.end_year)
					report_mismatch("end_year", result.end_year, want.end_year);
				if (result.start_valid !== want.start_valid)
					report_mismatch("start_valid", result.start_valid, want.start_valid);
			end
		end
	end

	initial begin
		win_lo = MIN_YEAR_RST;
		win_hi = MAX_YEAR_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_year_window();
		test_random_dates();
		drain_dates();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_dates.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/cdad_pkg.sv
design/cdad_fsm.sv
design/cdad_datapath.sv
design/calendar_date_add_days_unit.sv
tb/calendar_date_add_days_unit_test.sv
